// ----- sv/gkc_pkg.sv -----
// Shared constants and types for the Gabor kernel 2D convolution unit.
// No dependencies; imported by the unit.
`default_nettype none
package gkc_pkg;

    localparam int MAX_KERNEL_DEF = 15;
    localparam int MAX_WIDTH_DEF  = 1024;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_KERNEL_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    // input kinds carried on tuser
    localparam logic ACT_COEF  = 1'b0;
    localparam logic ACT_PIXEL = 1'b1;

    localparam logic [3:0]  KS_RESET = 4'd15;
    localparam logic [10:0] IW_RESET = 11'd640;
    localparam logic [10:0] IH_RESET = 11'd480;

    localparam logic signed [33:0] VAL_MAX = 34'sd1073741823;
    localparam logic signed [33:0] VAL_MIN = -34'sd1073741824;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- sv/gkc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module gkc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/gabor_kernel_convolution_2d_unit.sv -----
// Top level of the 2D convolution unit: coefficient store, line store, MAC sequencer.
// Depends on gkc_pkg and gkc_ram.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready | tuser: kind; tdata: coef_x, coef_y,
//           |     |                     |        coef_value, pixel
//  m_*      | out | m_tvalid / m_tready | tdata: out_x, out_y, value
//  APB      | in  | psel,penable,pready | kernel_size, image_width, image_height
//
// Interior pixel: one multiply-accumulate per cycle, one tap read per cycle from each
// memory port.
// Reset (synchronous, active low) clears the counters, the sequencer and the output
// register and restores the registers to 15 / 640 / 480. Memories are not cleared.
// A result waits in the output register; the next request is accepted meanwhile and
// only the handover of its own result waits for m_tready.
`default_nettype none
module gabor_kernel_convolution_2d_unit #(
    parameter int MAX_KERNEL = gkc_pkg::MAX_KERNEL_DEF,
    parameter int MAX_WIDTH  = gkc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // coef_x[3:0] coef_y[7:4] coef_value[23:8] pixel[31:24]
    input  wire logic        s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // out_x[9:0] out_y[19:10] value[50:20] zero pad
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import gkc_pkg::*;

    localparam int KB   = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CB   = $clog2(MAX_WIDTH);
    localparam int WLIM = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int HMAX = (MAX_KERNEL - 1) >> 1;

    // request fields
    logic [3:0]         coef_x, coef_y;
    logic signed [15:0] coef_value;
    logic [7:0]         pixel;
    assign coef_x     = s_tdata[3:0];
    assign coef_y     = s_tdata[7:4];
    assign coef_value = s_tdata[23:8];
    assign pixel      = s_tdata[31:24];

    // configuration
    logic [3:0]  r_ks;
    logic [10:0] r_iw, r_ih;
    logic        cfg_wr, cfg_geo;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_geo = cfg_wr && ((paddr[3:2] == REG_KERNEL_SIZE)
                             || (paddr[3:2] == REG_IMAGE_WIDTH)
                             || (paddr[3:2] == REG_IMAGE_HEIGHT));

    always_comb begin
        case (paddr[3:2])
            REG_KERNEL_SIZE:  prdata = {28'd0, r_ks};
            REG_IMAGE_WIDTH:  prdata = {21'd0, r_iw};
            REG_IMAGE_HEIGHT: prdata = {21'd0, r_ih};
            default:          prdata = 32'd0;
        endcase
    end

    // effective geometry
    logic [10:0] eff_w, eff_h;
    logic [2:0]  h;
    logic [3:0]  s_m1;      // effective kernel size minus one (2*h)
    logic [19:0] lag;       // h rows plus h columns, in pixels
    assign eff_w = (r_iw == 11'd0) ? 11'd1 : ((int'(r_iw) > WLIM) ? 11'(WLIM) : r_iw);
    assign eff_h = (r_ih == 11'd0) ? 11'd1 : ((r_ih > 11'd1024) ? 11'd1024 : r_ih);
    assign h     = (int'(r_ks[3:1]) > HMAX) ? 3'(HMAX) : r_ks[3:1];
    assign s_m1  = {h, 1'b0};
    assign lag   = 20'(h) * 20'(eff_w) + 20'(h);

    // frame counters
    t_state          r_state, n_state;
    logic [9:0]      r_col, r_row, r_ox, r_oy, r_px, r_py;
    logic [19:0]     r_lin;     // raster index of the next pixel in the frame
    logic [KB-1:0]   r_rslot, r_oslot;
    logic            acc_pix, acc_coef, first, emit, border;
    logic [9:0]      cur_ox, cur_oy;
    logic [KB-1:0]   cur_oslot, start_slot;
    logic [KB+3:0]   slot_t;
    logic [10:0]     col1, row1;

    assign acc_pix  = s_tvalid && s_tready && (s_tuser == ACT_PIXEL);
    assign acc_coef = s_tvalid && s_tready && (s_tuser == ACT_COEF);
    // first emitted position of the frame is (0,0)
    assign first    = (r_lin == lag);
    assign cur_ox    = first ? 10'd0 : r_ox;
    assign cur_oy    = first ? 10'd0 : r_oy;
    assign cur_oslot = first ? '0 : r_oslot;
    // output lags input by h rows plus h columns
    assign emit   = (r_lin >= lag);
    assign border = (cur_ox < 10'(h)) || (cur_oy < 10'(h))
                 || ({1'b0, cur_ox} + 11'(h) >= eff_w) || ({1'b0, cur_oy} + 11'(h) >= eff_h);
    assign col1   = {1'b0, r_col} + 11'd1;
    assign row1   = {1'b0, r_row} + 11'd1;
    // (oy - h) mod MAX_KERNEL
    assign slot_t = (KB+4)'(cur_oslot) + (KB+4)'(MAX_KERNEL) - (KB+4)'(h);
    assign start_slot = (slot_t >= (KB+4)'(MAX_KERNEL)) ? KB'(slot_t - (KB+4)'(MAX_KERNEL))
                                                        : KB'(slot_t);

    function automatic logic [KB-1:0] slot_inc(input logic [KB-1:0] s);
        slot_inc = (s == KB'(MAX_KERNEL - 1)) ? '0 : s + KB'(1);
    endfunction

    // tap sequencer
    logic [3:0]   r_i, r_j;
    logic [9:0]   r_lcol;
    logic [KB-1:0] r_lslot;
    logic         r_issue, r_v1, r_l1, r_v2, r_l2;
    logic signed [24:0] r_prod;
    logic signed [33:0] r_acc;
    logic         last_tap;
    assign last_tap = (r_i == s_m1) && (r_j == s_m1);

    // memories
    logic [15:0] k_rdata;
    logic [7:0]  l_rdata;
    logic        k_we;
    assign k_we = acc_coef && (int'(coef_x) < MAX_KERNEL) && (int'(coef_y) < MAX_KERNEL);

    gkc_ram #(.WIDTH(16), .DEPTH(1 << (2 * KB))) u_kernel_ram (
        .i_clk   (i_clk),
        .i_we    (k_we),
        .i_waddr ({KB'(coef_y), KB'(coef_x)}),
        .i_wdata (coef_value),
        .i_raddr ({KB'(s_m1 - r_j), KB'(s_m1 - r_i)}),   // flipped kernel
        .o_rdata (k_rdata)
    );

    gkc_ram #(.WIDTH(8), .DEPTH(1 << (KB + CB))) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (acc_pix),
        .i_waddr ({r_rslot, CB'(r_col)}),
        .i_wdata (pixel),
        .i_raddr ({r_lslot, CB'(r_lcol)}),
        .o_rdata (l_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc_pix && emit) begin
                    n_state = border ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_v2 && r_l2) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid || m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        case (r_state)
            S_IDLE:  s_tready = 1'b1;
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ks     <= KS_RESET;
            r_iw     <= IW_RESET;
            r_ih     <= IH_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_lin    <= '0;
            r_rslot  <= '0;
            r_ox     <= '0;
            r_oy     <= '0;
            r_oslot  <= '0;
            r_issue  <= 1'b0;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;

            // a geometry write restarts the frame
            if (cfg_geo) begin
                case (paddr[3:2])
                    REG_KERNEL_SIZE:  r_ks <= pwdata[3:0];
                    REG_IMAGE_WIDTH:  r_iw <= pwdata[10:0];
                    REG_IMAGE_HEIGHT: r_ih <= pwdata[10:0];
                    default: ;
                endcase
                r_col   <= '0;
                r_row   <= '0;
                r_lin   <= '0;
                r_rslot <= '0;
            end else if (acc_pix) begin
                if (col1 >= eff_w) begin
                    r_col <= '0;
                    if (row1 >= eff_h) begin
                        r_row   <= '0;
                        r_rslot <= '0;
                        r_lin   <= '0;
                    end else begin
                        r_row   <= row1[9:0];
                        r_rslot <= slot_inc(r_rslot);
                        r_lin   <= r_lin + 20'd1;
                    end
                end else begin
                    r_col <= col1[9:0];
                    r_lin <= r_lin + 20'd1;
                end
            end

            if (acc_pix && emit) begin
                r_px  <= cur_ox;
                r_py  <= cur_oy;
                r_acc <= '0;
                if ({1'b0, cur_ox} + 11'd1 >= eff_w) begin
                    r_ox    <= '0;
                    r_oy    <= cur_oy + 10'd1;
                    r_oslot <= slot_inc(cur_oslot);
                end else begin
                    r_ox    <= cur_ox + 10'd1;
                    r_oy    <= cur_oy;
                    r_oslot <= cur_oslot;
                end
                if (!border) begin
                    r_issue <= 1'b1;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_lcol  <= cur_ox - 10'(h);
                    r_lslot <= start_slot;
                end
            end

            // issue one tap per cycle, row by row
            if (r_issue) begin
                if (last_tap) begin
                    r_issue <= 1'b0;
                end
                if (r_i == s_m1) begin
                    r_i     <= '0;
                    r_j     <= r_j + 4'd1;
                    r_lcol  <= r_px - 10'(h);
                    r_lslot <= slot_inc(r_lslot);
                end else begin
                    r_i    <= r_i + 4'd1;
                    r_lcol <= r_lcol + 10'd1;
                end
            end
            r_v1 <= r_issue;
            r_l1 <= last_tap;
            r_v2 <= r_v1;
            r_l2 <= r_l1;
            r_prod <= $signed(k_rdata) * $signed({1'b0, l_rdata});
            if (r_v2) begin
                r_acc <= r_acc + {{9{r_prod[24]}}, r_prod};
            end

            // output register
            if ((r_state == S_DONE) && (!m_tvalid || m_tready)) begin
                m_tvalid       <= 1'b1;
                m_tdata[9:0]   <= r_px;
                m_tdata[19:10] <= r_py;
                m_tdata[55:51] <= '0;
                if (r_acc > VAL_MAX) begin
                    m_tdata[50:20] <= VAL_MAX[30:0];
                end else if (r_acc < VAL_MIN) begin
                    m_tdata[50:20] <= VAL_MIN[30:0];
                end else begin
                    m_tdata[50:20] <= r_acc[30:0];
                end
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/gkc_checker.sv -----
// Port-level checker for the 2D convolution unit, bound to the top level.
// Depends on gabor_kernel_convolution_2d_unit.
`default_nettype none
module gkc_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata
);
    // a pending result stays until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // no result is ever ready the cycle after a request lands in an empty output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared too early");

    // result padding bits stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[55:51] == 5'd0))
        else $error("pad bits set");

    // no result comes out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("valid after reset");
endmodule

bind gabor_kernel_convolution_2d_unit gkc_props u_gkc_props (.*);
`default_nettype wire
